// ===== src/cpt_pkg.sv =====
// shared constants and types of the closest point on triangle core
package cpt_pkg;

	// default geometry widths
	localparam int COORD_WIDTH_DEF     = 24;
	localparam int RATIO_FRAC_BITS_DEF = 16;
	localparam int DOT_WIDTH_DEF       = 2 * (COORD_WIDTH_DEF + 1) + 2;
	localparam int NUM_WIDTH_DEF       = 2 * DOT_WIDTH_DEF + 3;

	// voronoi region codes
	typedef enum logic [2:0] {
		REG_VERT_A  = 3'd0,
		REG_VERT_B  = 3'd1,
		REG_EDGE_AB = 3'd2,
		REG_VERT_C  = 3'd3,
		REG_EDGE_AC = 3'd4,
		REG_EDGE_BC = 3'd5,
		REG_FACE    = 3'd6
	} region_t;

endpackage

// ===== src/cpt_smul.sv =====
// two-stage signed multiplier built from four half-width partial products
module cpt_smul #(
	parameter int W = cpt_pkg::DOT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] p
);
	localparam int H  = (W + 1) / 2;
	localparam int HW = W - H;
	localparam int PW = 2 * W;

	logic        [2*H-1:0]    ll_s1;
	logic signed [HW+H:0]     lh_s1;
	logic signed [HW+H:0]     hl_s1;
	logic signed [2*HW-1:0]   hh_s1;

	// partial products
	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= a[H-1:0] * b[H-1:0];
			lh_s1 <= $signed({1'b0, a[H-1:0]}) * $signed(b[W-1:H]);
			hl_s1 <= $signed(a[W-1:H]) * $signed({1'b0, b[H-1:0]});
			hh_s1 <= $signed(a[W-1:H]) * $signed(b[W-1:H]);
		end
	end

	// recombine
	always_ff @(posedge clk) begin
		if (en) begin
			p <= $signed(PW'(ll_s1)) + (PW'(lh_s1) <<< H) + (PW'(hl_s1) <<< H)
				+ (PW'(hh_s1) <<< (2 * H));
		end
	end

endmodule

// ===== src/cpt_ratio.sv =====
// pipelined restoring divider giving a clamped fraction num/den, one bit a stage
module cpt_ratio #(
	parameter int NW  = cpt_pkg::NUM_WIDTH_DEF,
	parameter int RFB = cpt_pkg::RATIO_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic signed [NW-1:0] den,
	output logic        [RFB:0]  ratio
);
	localparam int RW = NW - 1;

	logic [RW-1:0]  rem_sk  [RFB+1];
	logic [RW-1:0]  den_sk  [RFB+1];
	logic [RFB-1:0] q_sk    [RFB+1];
	logic           full_sk [RFB+1];

	// range check: non-positive gives zero, at or above den gives one
	always_ff @(posedge clk) begin
		if (en) begin
			full_sk[0] <= !(num <= 0) && (num >= den);
			rem_sk[0]  <= (num <= 0) ? '0 : num[RW-1:0];
			den_sk[0]  <= den[RW-1:0];
			q_sk[0]    <= '0;
		end
	end

	// one quotient bit per stage
	for (genvar k = 1; k <= RFB; k++) begin : g_step
		logic [RW:0] r2;
		logic        ge;
		assign r2 = {rem_sk[k-1], 1'b0};
		assign ge = r2 >= {1'b0, den_sk[k-1]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_sk[k]  <= ge ? RW'(r2 - {1'b0, den_sk[k-1]}) : RW'(r2);
				den_sk[k]  <= den_sk[k-1];
				q_sk[k]    <= {q_sk[k-1][RFB-2:0], ge};
				full_sk[k] <= full_sk[k-1];
			end
		end
	end

	assign ratio = full_sk[RFB] ? ((RFB+1)'(1) << RFB) : {1'b0, q_sk[RFB]};

endmodule

// ===== src/closest_point_on_triangle_core.sv =====
// closest point on triangle core: top level pipeline
// stages: s1..s8, then the ratio divider, then s9 and s10 from input beat to result
// throughput: one beat per cycle while the skid is empty; the length is set by the one-bit-a-stage ratio divider
// a skid register on the output holds one refused result, and the pipeline stalls while it is full
// reset: asynchronous, clears the stage valid bits and the skid valid flag; data registers keep
module closest_point_on_triangle_core #(
	parameter int COORD_WIDTH     = cpt_pkg::COORD_WIDTH_DEF,
	parameter int RATIO_FRAC_BITS = cpt_pkg::RATIO_FRAC_BITS_DEF,
	localparam int IN_TW  = ((12 * COORD_WIDTH + 7) / 8) * 8,
	localparam int OUT_TW = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
	input  logic [IN_TW-1:0]  s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// near_x, near_y, near_z
	output logic [OUT_TW-1:0] m_tdata,
	// region [2:0], degenerate [3]
	output logic [3:0]        m_tuser
);
	localparam int CW   = COORD_WIDTH;
	localparam int RFB  = RATIO_FRAC_BITS;
	localparam int DW   = CW + 1;
	localparam int PRW  = 2 * DW;
	localparam int DOTW = PRW + 2;
	localparam int CRW  = 2 * DOTW + 1;
	localparam int NW   = CRW + 2;
	localparam int QW   = RFB + 1;
	localparam int FW   = QW + 1 + DW;
	localparam int SW   = FW + 1;
	localparam int TW   = SW + 1;
	localparam logic signed [TW-1:0] SAT_HI = {{(TW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [TW-1:0] SAT_LO = ~SAT_HI;

	typedef struct packed {
		logic [2:0][CW-1:0] a;
		logic [2:0][CW-1:0] b;
		logic [2:0][CW-1:0] c;
		logic [2:0][DW-1:0] ab;
		logic [2:0][DW-1:0] ac;
		logic [2:0][DW-1:0] bc;
	} geom_t;

	typedef struct packed {
		logic c0, c1, c3;
		logic d1ge0, d2ge0, d3le0, d6le0;
		logic e1ge0, e2ge0;
		logic den2le0, den4le0, den5le0;
		logic vale0, vble0, vcle0;
	} flags_t;

	typedef struct packed {
		logic [2:0][CW-1:0] base;
		logic [2:0][DW-1:0] dir1;
		logic [2:0][DW-1:0] dir2;
		cpt_pkg::region_t   region;
		logic               degen;
	} pay_t;

	typedef struct packed {
		logic [2:0][CW-1:0] near;
		cpt_pkg::region_t   region;
		logic               degen;
	} out_t;

	logic en;
	logic skid_vld_q;
	out_t skid_q;

	logic [CW-1:0] f [12];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	geom_t geo_s1, geo_s2, geo_s3, geo_s4, geo_s5, geo_s6, geo_s7;
	logic [2:0][DW-1:0] ap_s1, bp_s1, cp_s1;
	logic signed [PRW-1:0]  pr_s2 [6][3];
	logic signed [DOTW-1:0] d_s3 [6];
	logic signed [2*DOTW-1:0] m [6];
	flags_t fl4_d, fl5_d, fl6_d, fl7_d;
	flags_t fl_s4, fl_s5, fl_s6, fl_s7;
	logic signed [DOTW-1:0] d1_s4, d1_s5, d1_s6, d1_s7;
	logic signed [DOTW-1:0] d2_s4, d2_s5, d2_s6, d2_s7;
	logic signed [DOTW:0]   e1_s4, e1_s5, e1_s6, e1_s7, e2_s4;
	logic signed [DOTW:0]   den2_s4, den2_s5, den2_s6, den2_s7;
	logic signed [DOTW:0]   den4_s4, den4_s5, den4_s6, den4_s7;
	logic signed [DOTW+1:0] den5_s5, den5_s6, den5_s7;
	logic signed [CRW-1:0]  va_s6, vb_s6, vc_s6, vb_s7, vc_s7;
	logic signed [NW-1:0]   denf_s7;

	pay_t pay_d, pay_s8;
	logic signed [NW-1:0] num0_d, num1_d, den_d, num0_s8, num1_s8, den_s8;
	logic [QW-1:0] rv, rw;
	pay_t pay_dl [RFB+1];
	logic v_dl [RFB+1];

	logic signed [FW-1:0] p1_s9 [3];
	logic signed [FW-1:0] p2_s9 [3];
	pay_t pay_s9;
	out_t out_d, out_s10, od;

	// stall only while the skid holds a beat
	assign en       = !skid_vld_q;
	assign s_tready = en;

	// unpack input beat
	always_comb begin
		for (int j = 0; j < 12; j++) begin
			f[j] = s_tdata[j*CW +: CW];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0; v_s4 <= 1'b0; v_s5 <= 1'b0;
			v_s6 <= 1'b0; v_s7 <= 1'b0; v_s8 <= 1'b0; v_s9 <= 1'b0; v_s10 <= 1'b0;
			for (int k = 0; k <= RFB; k++) v_dl[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_dl[0] <= v_s8;
			for (int k = 1; k <= RFB; k++) v_dl[k] <= v_dl[k-1];
			v_s9 <= v_dl[RFB];
			v_s10 <= v_s9;
		end
	end

	// s1: edge and offset vectors
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				geo_s1.a[i]  <= f[3+i];
				geo_s1.b[i]  <= f[6+i];
				geo_s1.c[i]  <= f[9+i];
				geo_s1.ab[i] <= DW'($signed(f[6+i])) - DW'($signed(f[3+i]));
				geo_s1.ac[i] <= DW'($signed(f[9+i])) - DW'($signed(f[3+i]));
				geo_s1.bc[i] <= DW'($signed(f[9+i])) - DW'($signed(f[6+i]));
				ap_s1[i]     <= DW'($signed(f[i])) - DW'($signed(f[3+i]));
				bp_s1[i]     <= DW'($signed(f[i])) - DW'($signed(f[6+i]));
				cp_s1[i]     <= DW'($signed(f[i])) - DW'($signed(f[9+i]));
			end
		end
	end

	// s2: component products of the six dot products
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s2 <= geo_s1;
			for (int i = 0; i < 3; i++) begin
				pr_s2[0][i] <= $signed(geo_s1.ab[i]) * $signed(ap_s1[i]);
				pr_s2[1][i] <= $signed(geo_s1.ac[i]) * $signed(ap_s1[i]);
				pr_s2[2][i] <= $signed(geo_s1.ab[i]) * $signed(bp_s1[i]);
				pr_s2[3][i] <= $signed(geo_s1.ac[i]) * $signed(bp_s1[i]);
				pr_s2[4][i] <= $signed(geo_s1.ab[i]) * $signed(cp_s1[i]);
				pr_s2[5][i] <= $signed(geo_s1.ac[i]) * $signed(cp_s1[i]);
			end
		end
	end

	// s3: dot product sums d1..d6
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s3 <= geo_s2;
			for (int k = 0; k < 6; k++) begin
				d_s3[k] <= DOTW'(pr_s2[k][0]) + DOTW'(pr_s2[k][1]) + DOTW'(pr_s2[k][2]);
			end
		end
	end

	// s4..s5: cross terms of the barycentric numerators
	cpt_smul #(.W(DOTW)) u_m0 (.clk(clk), .en(en), .a(d_s3[0]), .b(d_s3[3]), .p(m[0]));
	cpt_smul #(.W(DOTW)) u_m1 (.clk(clk), .en(en), .a(d_s3[2]), .b(d_s3[1]), .p(m[1]));
	cpt_smul #(.W(DOTW)) u_m2 (.clk(clk), .en(en), .a(d_s3[4]), .b(d_s3[1]), .p(m[2]));
	cpt_smul #(.W(DOTW)) u_m3 (.clk(clk), .en(en), .a(d_s3[0]), .b(d_s3[5]), .p(m[3]));
	cpt_smul #(.W(DOTW)) u_m4 (.clk(clk), .en(en), .a(d_s3[2]), .b(d_s3[5]), .p(m[4]));
	cpt_smul #(.W(DOTW)) u_m5 (.clk(clk), .en(en), .a(d_s3[4]), .b(d_s3[3]), .p(m[5]));

	// vertex test flags
	always_comb begin
		fl4_d       = '0;
		fl4_d.c0    = (d_s3[0] <= 0) && (d_s3[1] <= 0);
		fl4_d.c1    = (d_s3[2] >= 0) && (d_s3[2] >= d_s3[3]);
		fl4_d.c3    = (d_s3[5] >= 0) && (d_s3[5] >= d_s3[4]);
		fl4_d.d1ge0 = d_s3[0] >= 0;
		fl4_d.d2ge0 = d_s3[1] >= 0;
		fl4_d.d3le0 = d_s3[2] <= 0;
		fl4_d.d6le0 = d_s3[5] <= 0;
	end

	// s4: vertex tests and edge differences
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s4      <= geo_s3;
			fl_s4       <= fl4_d;
			d1_s4       <= d_s3[0];
			d2_s4       <= d_s3[1];
			e1_s4       <= (DOTW+1)'(d_s3[3]) - (DOTW+1)'(d_s3[2]);
			e2_s4       <= (DOTW+1)'(d_s3[4]) - (DOTW+1)'(d_s3[5]);
			den2_s4     <= (DOTW+1)'(d_s3[0]) - (DOTW+1)'(d_s3[2]);
			den4_s4     <= (DOTW+1)'(d_s3[1]) - (DOTW+1)'(d_s3[5]);
		end
	end

	// edge difference signs
	always_comb begin
		fl5_d         = fl_s4;
		fl5_d.e1ge0   = e1_s4 >= 0;
		fl5_d.e2ge0   = e2_s4 >= 0;
		fl5_d.den2le0 = den2_s4 <= 0;
		fl5_d.den4le0 = den4_s4 <= 0;
	end

	// s5: edge denominators and their signs
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s5        <= geo_s4;
			fl_s5         <= fl5_d;
			d1_s5         <= d1_s4;
			d2_s5         <= d2_s4;
			e1_s5         <= e1_s4;
			den2_s5       <= den2_s4;
			den4_s5       <= den4_s4;
			den5_s5       <= (DOTW+2)'(e1_s4) + (DOTW+2)'(e2_s4);
		end
	end

	// edge bc denominator sign
	always_comb begin
		fl6_d         = fl_s5;
		fl6_d.den5le0 = den5_s5 <= 0;
	end

	// s6: barycentric numerators va, vb, vc
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s6        <= geo_s5;
			fl_s6         <= fl6_d;
			d1_s6         <= d1_s5;
			d2_s6         <= d2_s5;
			e1_s6         <= e1_s5;
			den2_s6       <= den2_s5;
			den4_s6       <= den4_s5;
			den5_s6       <= den5_s5;
			vc_s6         <= CRW'(m[0]) - CRW'(m[1]);
			vb_s6         <= CRW'(m[2]) - CRW'(m[3]);
			va_s6         <= CRW'(m[4]) - CRW'(m[5]);
		end
	end

	// barycentric numerator signs
	always_comb begin
		fl7_d       = fl_s6;
		fl7_d.vale0 = va_s6 <= 0;
		fl7_d.vble0 = vb_s6 <= 0;
		fl7_d.vcle0 = vc_s6 <= 0;
	end

	// s7: face denominator and numerator signs
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s7      <= geo_s6;
			fl_s7       <= fl7_d;
			d1_s7       <= d1_s6;
			d2_s7       <= d2_s6;
			e1_s7       <= e1_s6;
			den2_s7     <= den2_s6;
			den4_s7     <= den4_s6;
			den5_s7     <= den5_s6;
			vb_s7       <= vb_s6;
			vc_s7       <= vc_s6;
			denf_s7     <= NW'(va_s6) + NW'(vb_s6) + NW'(vc_s6);
		end
	end

	// region decision in test order
	always_comb begin
		pay_d.base   = geo_s7.a;
		pay_d.dir1   = '0;
		pay_d.dir2   = '0;
		pay_d.region = cpt_pkg::REG_VERT_A;
		pay_d.degen  = 1'b0;
		num0_d       = '0;
		num1_d       = '0;
		den_d        = NW'(1);
		if (fl_s7.c0) begin
			pay_d.region = cpt_pkg::REG_VERT_A;
		end else if (fl_s7.c1) begin
			pay_d.base   = geo_s7.b;
			pay_d.region = cpt_pkg::REG_VERT_B;
		end else if (fl_s7.vcle0 && fl_s7.d1ge0 && fl_s7.d3le0) begin
			if (fl_s7.den2le0) begin
				pay_d.degen = 1'b1;
			end else begin
				pay_d.dir1   = geo_s7.ab;
				pay_d.region = cpt_pkg::REG_EDGE_AB;
				num0_d       = NW'(d1_s7);
				den_d        = NW'(den2_s7);
			end
		end else if (fl_s7.c3) begin
			pay_d.base   = geo_s7.c;
			pay_d.region = cpt_pkg::REG_VERT_C;
		end else if (fl_s7.vble0 && fl_s7.d2ge0 && fl_s7.d6le0) begin
			if (fl_s7.den4le0) begin
				pay_d.degen = 1'b1;
			end else begin
				pay_d.dir1   = geo_s7.ac;
				pay_d.region = cpt_pkg::REG_EDGE_AC;
				num0_d       = NW'(d2_s7);
				den_d        = NW'(den4_s7);
			end
		end else if (fl_s7.vale0 && fl_s7.e1ge0 && fl_s7.e2ge0) begin
			if (fl_s7.den5le0) begin
				pay_d.degen = 1'b1;
			end else begin
				pay_d.base   = geo_s7.b;
				pay_d.dir1   = geo_s7.bc;
				pay_d.region = cpt_pkg::REG_EDGE_BC;
				num0_d       = NW'(e1_s7);
				den_d        = NW'(den5_s7);
			end
		end else if (denf_s7 <= 0) begin
			pay_d.degen = 1'b1;
		end else begin
			pay_d.dir1   = geo_s7.ab;
			pay_d.dir2   = geo_s7.ac;
			pay_d.region = cpt_pkg::REG_FACE;
			num0_d       = NW'(vb_s7);
			num1_d       = NW'(vc_s7);
			den_d        = denf_s7;
		end
	end

	// s8: chosen operands
	always_ff @(posedge clk) begin
		if (en) begin
			pay_s8  <= pay_d;
			num0_s8 <= num0_d;
			num1_s8 <= num1_d;
			den_s8  <= den_d;
		end
	end

	// ratio dividers, payload follows alongside
	cpt_ratio #(.NW(NW), .RFB(RFB)) u_rv (
		.clk(clk), .en(en), .num(num0_s8), .den(den_s8), .ratio(rv)
	);
	cpt_ratio #(.NW(NW), .RFB(RFB)) u_rw (
		.clk(clk), .en(en), .num(num1_s8), .den(den_s8), .ratio(rw)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			pay_dl[0] <= pay_s8;
			for (int k = 1; k <= RFB; k++) pay_dl[k] <= pay_dl[k-1];
		end
	end

	// s9: ratio times direction
	always_ff @(posedge clk) begin
		if (en) begin
			pay_s9 <= pay_dl[RFB];
			for (int i = 0; i < 3; i++) begin
				p1_s9[i] <= $signed({1'b0, rv}) * $signed(pay_dl[RFB].dir1[i]);
				p2_s9[i] <= $signed({1'b0, rw}) * $signed(pay_dl[RFB].dir2[i]);
			end
		end
	end

	// floor shift, add base, saturate
	always_comb begin
		logic signed [SW-1:0] sum;
		logic signed [SW-1:0] sh;
		logic signed [TW-1:0] tot;
		out_d.region = pay_s9.region;
		out_d.degen  = pay_s9.degen;
		for (int i = 0; i < 3; i++) begin
			sum = SW'(p1_s9[i]) + SW'(p2_s9[i]);
			sh  = sum >>> RFB;
			tot = TW'($signed(pay_s9.base[i])) + TW'(sh);
			if (tot > SAT_HI) begin
				out_d.near[i] = SAT_HI[CW-1:0];
			end else if (tot < SAT_LO) begin
				out_d.near[i] = SAT_LO[CW-1:0];
			end else begin
				out_d.near[i] = tot[CW-1:0];
			end
		end
	end

	// s10: result register
	always_ff @(posedge clk) begin
		if (en) begin
			out_s10 <= out_d;
		end
	end

	// output skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (m_tready) skid_vld_q <= 1'b0;
		end else if (v_s10 && !m_tready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q) begin
			skid_q <= out_s10;
		end
	end

	assign od       = skid_vld_q ? skid_q : out_s10;
	assign m_tvalid = skid_vld_q || v_s10;
	assign m_tdata  = OUT_TW'({od.near[2], od.near[1], od.near[0]});
	assign m_tuser  = {od.degen, od.region};

`ifndef SYNTHESIS
	// a degenerate result always reports vertex a
	a_degen_region: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && od.degen |-> od.region == cpt_pkg::REG_VERT_A)
		else $error("degenerate result with region other than vertex a");

	// a refused result beat is caught by the skid
	a_skid_catch: assert property (@(posedge clk) disable iff (!arst_n)
		v_s10 && !skid_vld_q && !m_tready |=> skid_vld_q)
		else $error("stalled result beat not held in skid");

	// the pipeline is frozen while the skid is full
	a_skid_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |=> $stable(v_s10))
		else $error("last stage moved while skid full");
`endif

endmodule
